>>> rtl/fde_pkg.sv
// shared types, widths and the divide-by-ten helper for the decimal factorial engine
// no dependencies; imported by every module of the block
package fde_pkg;

    localparam int MAX_DIGITS_DEF   = 256;
    localparam int GROUP_DIGITS_DEF = 16;

    localparam int N_W     = 8;   // width of the input number
    localparam int DIG_W   = 4;   // one bcd digit
    localparam int CNT_W   = 5;   // digit count of a group
    localparam int GROUP_W = 64;  // packed bcd group
    localparam int PROD_W  = 12;  // digit * multiplier + carry, at most 2549
    localparam int CARRY_W = 8;   // carry stays below the multiplier

    typedef struct packed {
        logic issue;      // digit read issued this cycle
        logic ext_step;   // peel one digit off the carry
        logic clr_carry;
    } t_mul_ctl;

    typedef struct packed {
        logic             wr;
        logic [DIG_W-1:0] wdata;
        logic             carry_nz;
        logic             busy;
    } t_mul_stat;

    typedef struct packed {
        logic             valid;
        logic [DIG_W-1:0] digit;
        logic             eog;
        logic             last;
        logic             ovf_push;
    } t_grp_req;

    typedef struct packed {
        logic [CARRY_W-1:0] q;
        logic [DIG_W-1:0]   r;
    } t_div10;

    // reciprocal multiply by 3277/32768, exact for values below 16384
    function automatic t_div10 fde_div10(input logic [PROD_W-1:0] v);
        logic [2*PROD_W-1:0] prod;
        logic [PROD_W-1:0]   q10;
        logic [PROD_W-1:0]   rem;
        t_div10              res;
        prod  = (2*PROD_W)'(v) * (2*PROD_W)'(3277);
        // quotient never exceeds 254 for the values fed in here
        res.q = prod[15+CARRY_W-1:15];
        q10   = {1'b0, res.q, 3'b000} + {3'b000, res.q, 1'b0};
        rem   = v - q10;
        res.r = rem[DIG_W-1:0];
        return res;
    endfunction

endpackage

>>> rtl/fde_digit_ram.sv
// digit store: one write port, one read port with registered read data
// depends on fde_pkg for the digit width
module fde_digit_ram #(
    parameter int DEPTH = fde_pkg::MAX_DIGITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [fde_pkg::DIG_W-1:0] i_wdata,
    input  logic [AW-1:0]           i_raddr,
    output logic [fde_pkg::DIG_W-1:0] o_rdata
);
    import fde_pkg::*;

    logic [DIG_W-1:0] r_mem [DEPTH];
    logic [DIG_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fde_mul_unit.sv
// digit-serial multiply stage: product register, carry register and divide by ten
// depends on fde_pkg for control structs and fde_div10
module fde_mul_unit #(
    parameter int AW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fde_pkg::t_mul_ctl           i_ctl,
    input  logic [AW-1:0]               i_idx,
    input  logic [fde_pkg::DIG_W-1:0]   i_rdata,
    input  logic [fde_pkg::N_W-1:0]     i_mult,
    output fde_pkg::t_mul_stat          o_stat,
    output logic [AW-1:0]               o_wr_idx
);
    import fde_pkg::*;

    logic               r_v1;
    logic               r_v2;
    logic [AW-1:0]      r_idx1;
    logic [AW-1:0]      r_idx2;
    logic [PROD_W-1:0]  r_p;
    logic [CARRY_W-1:0] r_carry;
    logic [PROD_W-1:0]  v;
    t_div10             d;

    // during carry extension only the carry itself is split
    always_comb begin
        if (i_ctl.ext_step) begin
            v = PROD_W'(r_carry);
        end else begin
            v = r_p + PROD_W'(r_carry);
        end
        d = fde_div10(v);
    end

    always_ff @(posedge i_clk) begin
        r_idx1 <= i_idx;
        r_idx2 <= r_idx1;
        r_p    <= PROD_W'(i_rdata) * PROD_W'(i_mult);
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_carry <= '0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
            if (i_ctl.clr_carry) begin
                r_carry <= '0;
            end else if (r_v2 || i_ctl.ext_step) begin
                r_carry <= d.q;
            end
        end
    end

    assign o_stat.wr       = r_v2 || i_ctl.ext_step;
    assign o_stat.wdata    = d.r;
    assign o_stat.carry_nz = (r_carry != '0);
    assign o_stat.busy     = r_v1 || r_v2;
    assign o_wr_idx        = r_idx2;

endmodule

>>> rtl/fde_group_out.sv
// packs the digit stream into bcd groups and holds the result register
// depends on fde_pkg for the request struct and field widths
module fde_group_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fde_pkg::t_grp_req             i_req,
    input  logic                          i_out_stall,
    output logic                          o_full,
    output logic                          o_out_valid,
    output logic [fde_pkg::GROUP_W-1:0]   o_digit_group,
    output logic [fde_pkg::CNT_W-1:0]     o_digit_count,
    output logic                          o_overflow,
    output logic                          o_last
);
    import fde_pkg::*;

    logic [GROUP_W-1:0] r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_full;
    logic               r_acc_last;
    logic               r_acc_ovf;
    logic               r_out_valid;
    logic [GROUP_W-1:0] r_group;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic               r_last;
    logic               xfer;

    assign xfer = r_full && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_group <= r_acc;
            r_count <= r_cnt;
            r_ovf   <= r_acc_ovf;
            r_last  <= r_acc_last;
        end
        if (i_req.valid) begin
            if (r_cnt == '0) begin
                r_acc <= GROUP_W'(i_req.digit);
            end else begin
                r_acc <= {r_acc[GROUP_W-DIG_W-1:0], i_req.digit};
            end
            if (i_req.eog) begin
                r_acc_last <= i_req.last;
                r_acc_ovf  <= 1'b0;
            end
        end
        if (i_req.ovf_push) begin
            r_acc      <= '0;
            r_acc_last <= 1'b1;
            r_acc_ovf  <= 1'b1;
        end
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (xfer) begin
                r_out_valid <= 1'b1;
                r_full      <= 1'b0;
                r_cnt       <= '0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // new digits only arrive while the accumulator is free
            if (i_req.valid) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (i_req.eog) begin
                    r_full <= 1'b1;
                end
            end
            if (i_req.ovf_push) begin
                r_cnt  <= '0;
                r_full <= 1'b1;
            end
        end
    end

    assign o_full        = r_full;
    assign o_out_valid   = r_out_valid;
    assign o_digit_group = r_group;
    assign o_digit_count = r_count;
    assign o_overflow    = r_ovf;
    assign o_last        = r_last;

endmodule

>>> rtl/decimal_factorial_engine_top.sv
// decimal factorial engine: one item at a time, n! built in a decimal digit memory
// steps: set to 1, per j=2..n multiply the digits in use and extend the carry,
// then emit by groups, one digit per cycle within a pass or a group; next n is
// taken when the last group left the accumulator or an overflow group entered it
// reset: synchronous, active low, clears control only; the digit memory is not
// cleared, every entry is written before it is read
module decimal_factorial_engine_top #(
    parameter int MAX_DIGITS   = fde_pkg::MAX_DIGITS_DEF,
    parameter int GROUP_DIGITS = fde_pkg::GROUP_DIGITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [fde_pkg::N_W-1:0]       i_n,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fde_pkg::GROUP_W-1:0]   o_digit_group,
    output logic [fde_pkg::CNT_W-1:0]     o_digit_count,
    output logic                          o_overflow,
    output logic                          o_last
);
    import fde_pkg::*;

    localparam int AW = $clog2(MAX_DIGITS);
    localparam logic [AW-1:0]    TOP_MAX    = AW'(MAX_DIGITS - 1);
    localparam logic [CNT_W-1:0] GRP_LEN    = CNT_W'(GROUP_DIGITS);
    localparam logic [CNT_W-1:0] PHASE_LAST = CNT_W'(GROUP_DIGITS - 1);
    localparam logic [CNT_W-1:0] PHASE_INIT = CNT_W'(1 % GROUP_DIGITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_MUL,
        S_DRAIN,
        S_EXT,
        S_OVF,
        S_GWAIT,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [N_W-1:0]   r_n;
    logic [N_W-1:0]   r_j;
    logic [AW-1:0]    r_top;
    logic [AW-1:0]    r_idx;
    logic [CNT_W-1:0] r_phase;
    logic [CNT_W-1:0] r_take;
    logic             r_first;
    logic             r_done;
    logic             r_e1;
    logic             r_e1_eog;
    logic             r_e1_last;

    logic [CNT_W-1:0] n_phase;
    logic [CNT_W-1:0] first_len;
    logic             emit_eog;
    logic             ext_step;
    logic             end_pass_emit;

    t_mul_ctl         mul_ctl;
    t_mul_stat        mul_stat;
    logic [AW-1:0]    mul_wr_idx;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [DIG_W-1:0] ram_wdata;
    logic [DIG_W-1:0] ram_rdata;
    t_grp_req         grp_req;
    logic             grp_full;

    always_comb begin
        n_phase       = (r_phase == PHASE_LAST) ? '0 : r_phase + CNT_W'(1);
        first_len     = (r_phase == '0) ? GRP_LEN : r_phase;
        emit_eog      = (r_take == CNT_W'(1));
        ext_step      = (r_state == S_EXT) && mul_stat.carry_nz && (r_top != TOP_MAX);
        end_pass_emit = (r_j == r_n);

        mul_ctl.issue     = (r_state == S_MUL);
        mul_ctl.ext_step  = ext_step;
        mul_ctl.clr_carry = (r_state == S_INIT);

        ram_we = (r_state == S_INIT) || mul_stat.wr;
        if (r_state == S_INIT) begin
            ram_waddr = '0;
            ram_wdata = DIG_W'(1);
        end else if (ext_step) begin
            ram_waddr = r_top + AW'(1);
            ram_wdata = mul_stat.wdata;
        end else begin
            ram_waddr = mul_wr_idx;
            ram_wdata = mul_stat.wdata;
        end

        grp_req.valid    = r_e1;
        grp_req.digit    = ram_rdata;
        grp_req.eog      = r_e1_eog;
        grp_req.last     = r_e1_last;
        grp_req.ovf_push = (r_state == S_OVF) && !grp_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_e1      <= 1'b0;
            r_e1_eog  <= 1'b0;
            r_e1_last <= 1'b0;
            r_done    <= 1'b0;
            r_first   <= 1'b0;
            r_top     <= '0;
            r_phase   <= '0;
        end else begin
            r_e1      <= (r_state == S_EMIT);
            r_e1_eog  <= emit_eog;
            r_e1_last <= emit_eog && (r_idx == '0);
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_n     <= i_n;
                        r_state <= S_INIT;
                    end
                end
                S_INIT: begin
                    r_top   <= '0;
                    r_phase <= PHASE_INIT;
                    r_j     <= N_W'(2);
                    r_idx   <= '0;
                    if (r_n < N_W'(2)) begin
                        r_first <= 1'b1;
                        r_done  <= 1'b0;
                        r_state <= S_GWAIT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_idx == r_top) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_DRAIN: begin
                    if (!mul_stat.busy) begin
                        r_state <= S_EXT;
                    end
                end
                S_EXT: begin
                    if (mul_stat.carry_nz) begin
                        if (r_top == TOP_MAX) begin
                            r_state <= S_OVF;
                        end else begin
                            r_top   <= r_top + AW'(1);
                            r_phase <= n_phase;
                        end
                    end else if (end_pass_emit) begin
                        r_idx   <= r_top;
                        r_first <= 1'b1;
                        r_done  <= 1'b0;
                        r_state <= S_GWAIT;
                    end else begin
                        r_j     <= r_j + N_W'(1);
                        r_idx   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_OVF: begin
                    if (!grp_full) begin
                        r_state <= S_IDLE;
                    end
                end
                S_GWAIT: begin
                    // wait for the previous group to leave the accumulator
                    if (!r_e1 && !grp_full) begin
                        if (r_done) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_take  <= r_first ? first_len : GRP_LEN;
                            r_first <= 1'b0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    r_take <= r_take - CNT_W'(1);
                    if (r_idx != '0) begin
                        r_idx <= r_idx - AW'(1);
                    end
                    if (emit_eog) begin
                        r_state <= S_GWAIT;
                        if (r_idx == '0) begin
                            r_done <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    fde_digit_ram #(
        .DEPTH (MAX_DIGITS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    fde_mul_unit #(
        .AW (AW)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (mul_ctl),
        .i_idx    (r_idx),
        .i_rdata  (ram_rdata),
        .i_mult   (r_j),
        .o_stat   (mul_stat),
        .o_wr_idx (mul_wr_idx)
    );

    fde_group_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (grp_req),
        .i_out_stall   (i_out_stall),
        .o_full        (grp_full),
        .o_out_valid   (o_out_valid),
        .o_digit_group (o_digit_group),
        .o_digit_count (o_digit_count),
        .o_overflow    (o_overflow),
        .o_last        (o_last)
    );

    a_ovf_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_last && (o_digit_count == '0)
            && (o_digit_group == '0))
        else $error("overflow request with payload");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_overflow |-> (o_digit_count != '0) && (o_digit_count <= GRP_LEN))
        else $error("group digit count out of range");

    a_idx_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_idx <= r_top))
        else $error("multiply pass past top digit");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e1 |-> !grp_full)
        else $error("digit arrived while accumulator full");

endmodule
